// File: hw/rtl/ctem_pkg.sv
// ----------------------------------------------------------------------------
// ctem_pkg
// Field types, register indexes and calendar constants for the
// calendar to epoch milliseconds unit.
// ----------------------------------------------------------------------------
package ctem_pkg;

    // item field types
    typedef logic [13:0] year_t;
    typedef logic [3:0]  month_t;
    typedef logic [4:0]  day_t;
    typedef logic [4:0]  hour_t;
    typedef logic [5:0]  minute_t;
    typedef logic [5:0]  second_t;
    typedef logic [9:0]  milli_t;
    typedef logic signed [48:0] epoch_ms_t;

    // configuration port
    typedef logic [1:0] cfg_index_t;
    typedef logic [5:0] cfg_data_t;

    localparam cfg_index_t CFG_OFFSET_HOURS   = 2'd0;
    localparam cfg_index_t CFG_OFFSET_MINUTES = 2'd1;
    localparam cfg_index_t CFG_OFFSET_IS_EAST = 2'd2;

    // calendar constants
    localparam int unsigned EPOCH_YEAR       = 1970;
    localparam int unsigned DAYS_PER_YEAR    = 365;
    localparam int unsigned LEAPS_TO_EPOCH   = 478;   // leap years in [0, 1969]
    localparam int unsigned MS_PER_SEC       = 1000;
    localparam int unsigned MS_PER_MIN       = 60000;
    localparam int unsigned MS_PER_HOUR      = 3600000;
    localparam int unsigned MS_PER_DAY       = 86400000;
    // floor(n / 100) == (n * DIV100_MUL) >> DIV100_SHIFT for n < 43690
    localparam int unsigned DIV100_MUL       = 5243;
    localparam int unsigned DIV100_SHIFT     = 19;

    // days before the first of the month, month already clamped to 1..12
    function automatic logic [8:0] days_before_month(input month_t m);
        logic [8:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// File: hw/rtl/calendar_to_epoch_milliseconds_unit.sv
// An accepted item moves through stages one, two, three and the output stage.
// Throughput: one item per cycle; the four-stage pipeline with per-stage
// valid bits takes a new item whenever stage one is empty or moving on.
// The widest path is the 24 x 28 bit signed day-to-millisecond multiply.
// Reset (aresetn low, synchronous) empties the pipeline and sets the offset
// registers to hours 0, minutes 0, east.
// ----------------------------------------------------------------------------
// calendar_to_epoch_milliseconds_unit
// Converts a proleptic Gregorian date and time to signed Unix milliseconds,
// corrected by a configured fixed UTC offset.
// ----------------------------------------------------------------------------
module calendar_to_epoch_milliseconds_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  ctem_pkg::cfg_index_t  cfg_index,
    input  ctem_pkg::cfg_data_t   cfg_data,
    // input items
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ctem_pkg::year_t       s_year_value,
    input  ctem_pkg::month_t      s_month_value,
    input  ctem_pkg::day_t        s_day_value,
    input  ctem_pkg::hour_t       s_hour_value,
    input  ctem_pkg::minute_t     s_minute_value,
    input  ctem_pkg::second_t     s_second_value,
    input  ctem_pkg::milli_t      s_milli_value,
    // result items
    output logic                  m_valid,
    input  logic                  m_ready,
    output ctem_pkg::epoch_ms_t   m_epoch_ms
);
    import ctem_pkg::*;

    localparam logic signed [27:0] DAY_MS = 28'(MS_PER_DAY);

    // configuration registers
    logic [3:0]         off_hours_reg;
    logic [5:0]         off_minutes_reg;
    logic               off_east_reg;
    logic [25:0]        off_mag;
    logic signed [26:0] off_ms_reg, off_ms_next;

    // stage enables
    logic en1, en2, en3, en4;

    // stage 1 registers
    logic               v1_reg;
    year_t              yr1_reg;
    logic [7:0]         q1_reg;
    logic signed [9:0]  doy1_reg;
    logic               gt2_1_reg;
    logic signed [23:0] ydays1_reg;
    logic [26:0]        tod1_reg;

    // stage 1 next values
    logic [26:0]        qmul;
    month_t             mon_c;
    logic signed [14:0] yoff;
    logic signed [23:0] ydays1_next;
    logic signed [9:0]  doy1_next;
    logic [26:0]        tod1_next;

    // stage 2 registers and next values
    logic               v2_reg;
    logic signed [23:0] days2_reg, days2_next;
    logic [26:0]        tod2_reg;
    logic [13:0]        rem_full;
    logic               rem_zero;
    logic               is_leap;
    year_t              yr_m1;
    logic [7:0]         qn;
    logic [12:0]        lb;

    // stage 3 registers and next values
    logic               v3_reg;
    logic signed [51:0] prod_full;
    logic [48:0]        prod3_reg;
    logic signed [28:0] add3_reg, add3_next;

    // stage 4 (output) registers
    logic               m_valid_reg;
    logic [48:0]        out_reg, out_next;

    // configuration writes, always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_hours_reg   <= '0;
            off_minutes_reg <= '0;
            off_east_reg    <= 1'b1;
            off_ms_reg      <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_OFFSET_HOURS:   off_hours_reg   <= cfg_data[3:0];
                    CFG_OFFSET_MINUTES: off_minutes_reg <= cfg_data;
                    CFG_OFFSET_IS_EAST: off_east_reg    <= cfg_data[0];
                    default: ;
                endcase
            end
            off_ms_reg <= off_ms_next;
        end
    end

    // offset in milliseconds, negated for an east offset
    assign off_mag = 26'(off_hours_reg) * 26'(MS_PER_HOUR)
                   + 26'(off_minutes_reg) * 26'(MS_PER_MIN);
    assign off_ms_next = off_east_reg ? -$signed({1'b0, off_mag})
                                      : $signed({1'b0, off_mag});

    // stage enables: a stage moves on when empty or when the next one moves
    assign en4     = !m_valid_reg || m_ready;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    // stage 1: year split, year days, day of year, time of day
    assign qmul  = 27'(s_year_value) * 27'(DIV100_MUL);
    assign mon_c = (s_month_value == 4'd0) ? 4'd1 :
                   (s_month_value > 4'd12) ? 4'd12 : s_month_value;
    assign yoff  = $signed({1'b0, s_year_value}) - 15'(EPOCH_YEAR);
    assign ydays1_next = 24'(yoff) * $signed(24'(DAYS_PER_YEAR));
    assign doy1_next = $signed({1'b0, days_before_month(mon_c)})
                     + $signed({5'b0, s_day_value}) - 10'sd1;
    assign tod1_next = 27'(s_hour_value) * 27'(MS_PER_HOUR)
                     + 27'(s_minute_value) * 27'(MS_PER_MIN)
                     + 27'(s_second_value) * 27'(MS_PER_SEC)
                     + 27'(s_milli_value);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            yr1_reg    <= s_year_value;
            q1_reg     <= qmul[DIV100_SHIFT +: 8];
            doy1_reg   <= doy1_next;
            gt2_1_reg  <= (mon_c > 4'd2);
            ydays1_reg <= ydays1_next;
            tod1_reg   <= tod1_next;
        end
    end

    // stage 2: leap day of this year and leap count since the epoch
    assign rem_full = yr1_reg - 14'(q1_reg * 14'd100);
    assign rem_zero = (rem_full == 14'd0);
    assign is_leap  = (yr1_reg[1:0] == 2'b00) && (!rem_zero || (q1_reg[1:0] == 2'b00));
    assign yr_m1    = yr1_reg - 14'd1;
    assign qn       = q1_reg - 8'(rem_zero);
    // leap years in [0, year - 1]; year zero has none before it
    assign lb = (yr1_reg == 14'd0) ? 13'd0
              : 13'(yr_m1 >> 2) - 13'(qn) + 13'(qn >> 2) + 13'd1;
    assign days2_next = ydays1_reg
                      + 24'(doy1_reg)
                      + $signed({23'b0, is_leap && gt2_1_reg})
                      + $signed({11'b0, lb})
                      - 24'(LEAPS_TO_EPOCH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            days2_reg <= days2_next;
            tod2_reg  <= tod1_reg;
        end
    end

    // stage 3: days to milliseconds, time of day plus offset
    assign prod_full = days2_reg * DAY_MS;
    assign add3_next = $signed({2'b0, tod2_reg}) + 29'(off_ms_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            prod3_reg <= prod_full[48:0];
            add3_reg  <= add3_next;
        end
    end

    // stage 4: final sum, wraps modulo 2^49
    assign out_next = prod3_reg + 49'(add3_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en4) begin
            m_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            out_reg <= out_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_epoch_ms = $signed(out_reg);

    // input held off only when every stage is full and the output stalls
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && v3_reg && m_valid_reg && !m_ready))
        else $error("input stalled with room in the pipeline");

    // a stalled stage two keeps its item
    a_stage2_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !en3) |=> (v2_reg && $stable(days2_reg)))
        else $error("stage two item lost under stall");

    // east offset gives a non-positive correction
    a_east_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        off_east_reg |=> (off_ms_reg <= 27'sd0))
        else $error("east offset not subtracted");

    // a leap year is always a multiple of four
    a_leap_mult4: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && is_leap) |-> (yr1_reg[1:0] == 2'b00))
        else $error("leap flag on a year not divisible by four");

endmodule

// File: test/calendar_to_epoch_milliseconds_unit_tb.sv
// ----------------------------------------------------------------------------
// calendar_to_epoch_milliseconds_unit_tb
// Drives dates into the calendar to epoch milliseconds unit under random
// gaps and back-pressure. Each accepted date is converted by a local
// calculation using the current offset registers. The expected millisecond
// count is then checked against the result items in order. The offset
// registers are rewritten between phases while the unit is idle.
// ----------------------------------------------------------------------------
module calendar_to_epoch_milliseconds_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ctem_pkg::*;

    localparam int unsigned RUN_LIMIT   = 300000;
    localparam int unsigned DRAIN_WAIT  = 10;
    localparam int unsigned LONG_STALL  = 400;
    localparam int unsigned MAX_REPORTS = 30;
    localparam cfg_index_t  CFG_UNUSED  = 2'd3;

    localparam longint SEC_PER_MIN  = 60;
    localparam longint SEC_PER_HOUR = 3600;
    localparam longint SEC_PER_DAY  = 86400;
    localparam longint SEC_PER_YEAR = 31536000;
    localparam longint MS_IN_SEC    = 1000;
    localparam longint UNIX_YEAR    = 1970;

    // days before the first of each month, index is the clamped month
    localparam int MONTH_START [13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243,
                                        273, 304, 334};
    // years around the leap rule boundaries and the epoch
    localparam int unsigned LEAP_EDGE_YEARS [16] = '{0, 4, 100, 400, 1600, 1700, 1800,
                                                     1900, 1968, 1969, 1970, 1971, 1972,
                                                     2000, 2100, 2400};

    typedef struct {
        year_t       year;
        month_t      month;
        day_t        day;
        hour_t       hour;
        minute_t     minute;
        second_t     second;
        milli_t      milli;
        int unsigned gap;
    } date_item_t;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index      = '0;
    cfg_data_t   cfg_data       = '0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    year_t       s_year_value   = '0;
    month_t      s_month_value  = '0;
    day_t        s_day_value    = '0;
    hour_t       s_hour_value   = '0;
    minute_t     s_minute_value = '0;
    second_t     s_second_value = '0;
    milli_t      s_milli_value  = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    epoch_ms_t   m_epoch_ms;

    // local copy of the offset registers
    logic [3:0]  zone_hours   = 4'd0;
    logic [5:0]  zone_minutes = 6'd0;
    logic        zone_east    = 1'b1;

    date_item_t  pending_dates_q [$];
    epoch_ms_t   epoch_ms_due_q [$];
    int unsigned send_wait    = 0;
    int unsigned recv_wait    = 0;
    int unsigned results_seen = 0;
    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;
    logic        send_burst   = 1'b0;
    logic        recv_eager   = 1'b0;

    calendar_to_epoch_milliseconds_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_year_value   (s_year_value),
        .s_month_value  (s_month_value),
        .s_day_value    (s_day_value),
        .s_hour_value   (s_hour_value),
        .s_minute_value (s_minute_value),
        .s_second_value (s_second_value),
        .s_milli_value  (s_milli_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_epoch_ms     (m_epoch_ms)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // leap years in [0, y-1]; year zero counts as leap
    function automatic longint leap_count(longint y);
        if (y <= 0) begin
            return 0;
        end
        return (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 + 1;
    endfunction

    // milliseconds since the epoch for one date under the current offset
    function automatic epoch_ms_t epoch_ms_of(year_t y, month_t mo, day_t d, hour_t h,
                                              minute_t mi, second_t s, milli_t ms);
        longint yr;
        longint mon;
        longint days;
        longint shift;
        longint secs;
        longint total;
        yr  = y;
        mon = mo;
        if (mon < 1) begin
            mon = 1;
        end
        if (mon > 12) begin
            mon = 12;
        end
        shift = longint'(zone_hours) * SEC_PER_HOUR + longint'(zone_minutes) * SEC_PER_MIN;
        if (zone_east) begin
            shift = -shift;
        end
        days = longint'(d) - 1 + MONTH_START[mon];
        // leap day of the current year only counts from March on
        if (mon > 2 && (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0))) begin
            days = days + 1;
        end
        days  = days + leap_count(yr) - leap_count(UNIX_YEAR);
        secs  = shift + longint'(s) + longint'(mi) * SEC_PER_MIN + longint'(h) * SEC_PER_HOUR
              + (yr - UNIX_YEAR) * SEC_PER_YEAR + days * SEC_PER_DAY;
        total = secs * MS_IN_SEC + longint'(ms);
        return epoch_ms_t'(total[48:0]);
    endfunction

    // mostly in range, sometimes an end of the range, sometimes any bit pattern
    function automatic int unsigned field_value(int unsigned lo, int unsigned hi,
                                                int unsigned top);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
            return $urandom_range(lo, hi);
        end
        if (roll < 88) begin
            return roll[0] ? hi : lo;
        end
        return $urandom_range(0, top);
    endfunction

    task automatic push_date(int unsigned y, int unsigned mo, int unsigned d, int unsigned h,
                             int unsigned mi, int unsigned s, int unsigned ms);
        date_item_t item;
        item.year   = year_t'(y);
        item.month  = month_t'(mo);
        item.day    = day_t'(d);
        item.hour   = hour_t'(h);
        item.minute = minute_t'(mi);
        item.second = second_t'(s);
        item.milli  = milli_t'(ms);
        if (send_burst || $urandom_range(0, 3) == 0) begin
            item.gap = 0;
        end else begin
            item.gap = $urandom_range(0, 12);
        end
        pending_dates_q.insert(pending_dates_q.size(), item);
    endtask

    task automatic push_random_dates(int unsigned count);
        int unsigned y;
        int unsigned roll;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
                y = $urandom_range(0, 9999);
            end else if (roll < 65) begin
                y = LEAP_EDGE_YEARS[$urandom_range(0, 15)];
            end else if (roll < 80) begin
                y = $urandom_range(1900, 2100);
            end else if (roll < 90) begin
                y = $urandom_range(0, 16383);
            end else begin
                y = (roll[0]) ? 9999 : ((roll[1]) ? 16383 : 0);
            end
            push_date(y, field_value(1, 12, 15), field_value(1, 31, 31),
                      field_value(0, 24, 31), field_value(0, 59, 63),
                      field_value(0, 59, 63), field_value(0, 999, 1023));
        end
    endtask

    // one register write, local copy follows on acceptance
    task automatic write_cfg(cfg_index_t idx, cfg_data_t data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_OFFSET_HOURS: begin
                zone_hours = data[3:0];
            end
            CFG_OFFSET_MINUTES: begin
                zone_minutes = data[5:0];
            end
            CFG_OFFSET_IS_EAST: begin
                zone_east = data[0];
            end
            default: begin
            end
        endcase
    endtask

    // settled view between edges: nothing queued, offered or outstanding
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_dates_q.size() != 0 || s_valid || epoch_ms_due_q.size() != 0);
    endtask

    task automatic run_offset_phase(cfg_data_t hours, cfg_data_t minutes, cfg_data_t east,
                                    int unsigned count);
        wait_idle();
        write_cfg(CFG_OFFSET_HOURS, hours);
        write_cfg(CFG_OFFSET_MINUTES, minutes);
        write_cfg(CFG_OFFSET_IS_EAST, east);
        @(negedge aclk);
        push_random_dates(count);
    endtask

    // sender: offers queued dates, predicts on acceptance
    always @(posedge aclk) begin
        date_item_t nxt;
        logic       offer;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            send_wait <= 0;
        end else begin
            offer = s_valid;
            if (s_valid && s_ready) begin
                epoch_ms_due_q.insert(epoch_ms_due_q.size(),
                                      epoch_ms_of(s_year_value, s_month_value,
                                                  s_day_value, s_hour_value,
                                                  s_minute_value, s_second_value,
                                                  s_milli_value));
                offer = 1'b0;
            end
            if (!offer) begin
                if (send_wait != 0) begin
                    send_wait <= send_wait - 1;
                end else if (pending_dates_q.size() != 0) begin
                    nxt = pending_dates_q.pop_front();
                    s_year_value   <= nxt.year;
                    s_month_value  <= nxt.month;
                    s_day_value    <= nxt.day;
                    s_hour_value   <= nxt.hour;
                    s_minute_value <= nxt.minute;
                    s_second_value <= nxt.second;
                    s_milli_value  <= nxt.milli;
                    send_wait      <= nxt.gap;
                    offer = 1'b1;
                end
            end
            s_valid <= offer;
        end
    end

    // receiver: checks each result item and stalls at random
    always @(posedge aclk) begin
        logic        got;
        int unsigned stall;
        epoch_ms_t   want;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_wait <= 0;
        end else begin
            got   = m_valid && m_ready;
            stall = recv_wait;
            if (got) begin
                if (epoch_ms_due_q.size() == 0) begin
                    error_count = error_count + 1;
                    if (error_count <= MAX_REPORTS) begin
                        $display("%0t: unexpected result, expected none, actual epoch_ms %0d",
                                 $time, m_epoch_ms);
                    end
                end else begin
                    want = epoch_ms_due_q.pop_front();
                    if (m_epoch_ms !== want) begin
                        error_count = error_count + 1;
                        if (error_count <= MAX_REPORTS) begin
                            $display("%0t: epoch_ms mismatch, expected %0d, actual %0d",
                                     $time, want, m_epoch_ms);
                        end
                    end
                end
                results_seen = results_seen + 1;
                // long hold-off so the pipeline fills and stalls the sender
                if (results_seen == 150 || results_seen == 400) begin
                    stall = LONG_STALL;
                end else if (recv_eager || $urandom_range(0, 3) == 0) begin
                    stall = 0;
                end else begin
                    stall = $urandom_range(0, 12);
                end
            end else if (stall != 0) begin
                stall = stall - 1;
            end
            recv_wait <= stall;
            m_ready   <= (stall == 0);
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("calendar_to_epoch_milliseconds_unit test failed");
            $finish;
        end
    end

    // stimulus and phases
    initial begin
        // directed dates under the reset offset (zero, east)
        push_date(1970, 1, 1, 0, 0, 0, 0);
        push_date(0, 1, 1, 0, 0, 0, 0);
        push_date(0, 0, 0, 0, 0, 0, 0);
        push_date(0, 2, 29, 12, 0, 0, 0);
        push_date(0, 3, 1, 0, 0, 0, 0);
        push_date(9999, 12, 31, 23, 59, 59, 999);
        push_date(16383, 15, 31, 31, 63, 63, 1023);
        push_date(1969, 12, 31, 23, 59, 59, 999);
        push_date(1969, 12, 31, 23, 59, 59, 1);
        push_date(2000, 2, 29, 0, 0, 0, 0);
        push_date(2000, 3, 1, 0, 0, 0, 0);
        push_date(1900, 3, 1, 0, 0, 0, 0);
        push_date(2100, 3, 1, 0, 0, 0, 0);
        push_date(2024, 3, 1, 0, 0, 0, 0);
        push_date(2023, 0, 15, 6, 30, 15, 500);
        push_date(2023, 13, 15, 6, 30, 15, 500);
        push_date(2023, 15, 1, 0, 0, 0, 0);
        push_date(2023, 5, 0, 0, 0, 0, 0);
        push_date(2023, 6, 30, 24, 0, 0, 0);
        push_date(1999, 2, 31, 0, 0, 0, 0);
        push_date(400, 3, 1, 0, 0, 0, 0);
        push_date(100, 3, 1, 0, 0, 0, 0);
        push_random_dates(50);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // widest west offset
        run_offset_phase(6'd14, 6'd59, 6'd0, 80);

        // widest east offset, back to back with no idling
        wait_idle();
        send_burst = 1'b1;
        recv_eager = 1'b1;
        run_offset_phase(6'd14, 6'd59, 6'd1, 70);
        wait_idle();
        send_burst = 1'b0;
        recv_eager = 1'b0;

        // register values beyond their documented range, upper data bits set
        run_offset_phase(6'h3F, 6'h3F, 6'h21, 60);

        // write to the unused index must leave the offset alone
        wait_idle();
        write_cfg(CFG_UNUSED, 6'h3F);
        run_offset_phase(6'd5, 6'd30, 6'd0, 80);

        // zero offset flagged west
        run_offset_phase(6'd0, 6'd0, 6'd0, 70);

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0 && epoch_ms_due_q.size() == 0) begin
            $display("calendar_to_epoch_milliseconds_unit test passed");
        end else begin
            $display("calendar_to_epoch_milliseconds_unit test failed");
        end
        $finish;
    end

endmodule

// File: calendar_to_epoch_milliseconds_unit.f
hw/rtl/ctem_pkg.sv
hw/rtl/calendar_to_epoch_milliseconds_unit.sv
test/calendar_to_epoch_milliseconds_unit_tb.sv
